>>> sv/llfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llfr_pkg : shared types and codes of the lead/length frame receiver
// Holds the operation and status codes, register indexes, the frame length
// limit and the item, result and frame-state structures.
// ----------------------------------------------------------------------------
package llfr_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned OPCODE_W   = 2;
	localparam int unsigned STATUS_W   = 3;
	localparam int unsigned CFG_IDX_W  = 1;

	// Longest frame accepted, lead and length bytes included
	localparam logic [BYTE_W-1:0] MAX_FRAME = 8'd64;

	// Operations
	localparam logic [OPCODE_W-1:0] OP_BYTE    = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_TICK    = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_NONE    = 2'd3;

	// Result status
	localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_STORED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_LEN_ERR  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_TICK     = 3'd5;
	localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd6;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_VALUE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_RELOAD = 1'd1;

	// Reset values of the configuration registers
	localparam logic [BYTE_W-1:0] LEAD_VALUE_RST = 8'd170;
	localparam logic [BYTE_W-1:0] GAP_RELOAD_RST = 8'd10;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [BYTE_W-1:0]   rx_byte;
	} llfr_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   byte_value;
		logic [BYTE_W-1:0]   byte_index;
		logic [BYTE_W-1:0]   frame_length;
		logic                gap_restart;
	} llfr_result_t;

	typedef struct packed {
		logic [BYTE_W-1:0] position;
		logic [BYTE_W-1:0] current_length;
		logic              frame_ready;
		logic [BYTE_W-1:0] gap_timer;
	} llfr_frame_t;

	typedef struct packed {
		logic [BYTE_W-1:0] lead_value;
		logic [BYTE_W-1:0] gap_reload;
	} llfr_cfg_t;

endpackage : llfr_pkg
`default_nettype wire

>>> sv/llfr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llfr_if : valid/ready channels of the frame receiver
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface llfr_in_if;
	import llfr_pkg::*;
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [BYTE_W-1:0]   rx_byte;

	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface : llfr_in_if

interface llfr_out_if;
	import llfr_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   byte_value;
	logic [BYTE_W-1:0]   byte_index;
	logic [BYTE_W-1:0]   frame_length;
	logic                gap_restart;

	modport source (output valid, output status, output byte_value, output byte_index,
		output frame_length, output gap_restart, input ready);
	modport sink   (input valid, input status, input byte_value, input byte_index,
		input frame_length, input gap_restart, output ready);
endinterface : llfr_out_if

interface llfr_cfg_if;
	import llfr_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface : llfr_cfg_if
`default_nettype wire

>>> sv/lead_length_frame_receiver_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lead_length_frame_receiver_top : length-prefixed deframer with gap timeout
// Item channel in, one result word out per item, configuration writes
// on a channel of their own.
//  - item: opcode 0 carries a received byte, 1 is a timer tick, 2 releases
//    a finished frame. Every item yields exactly one result word.
//  - result: status, stored byte and its index, frame length, gap-restart flag.
//  - cfg: index 0 writes the lead byte value, index 1 the gap reload.
//    Always ready; write only while no item is in flight.
//  - Path: an accepted word sits in the input stage, and its result is
//    loaded into the result register once that register is free.
//  - Throughput: one word per cycle while the receiver holds ready high;
//    a single pass of compares and 8-bit increments sits between the
//    input stage and the result register.
//  - Reset: frame state and gap timer clear, lead value returns to 170 and
//    gap reload to 10. The timer starts expired, so the first byte
//    reports a gap restart.
//  - Stall: while the receiver holds ready low the result word holds, the
//    input stage fills, and item ready drops once both stages are full.
// ----------------------------------------------------------------------------
module lead_length_frame_receiver_top #(
	parameter logic [llfr_pkg::BYTE_W-1:0] MAX_FRAME_LEN = llfr_pkg::MAX_FRAME
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	llfr_in_if.sink    item,
	llfr_out_if.source result,
	llfr_cfg_if.sink   cfg
);
	import llfr_pkg::*;

	// Input stage
	logic       valid_s1;
	llfr_item_t item_s1;

	// Frame state and configuration
	llfr_frame_t frame_q;
	llfr_frame_t frame_nxt;
	llfr_cfg_t   cfg_q;

	llfr_result_t step_res;
	logic         out_free;
	logic         advance;

	// The word in the input stage moves on whenever the result register
	// can take it; the input stage refills in the same cycle.
	assign advance    = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.opcode  <= item.opcode;
			item_s1.rx_byte <= item.rx_byte;
		end
	end

	// Advance the frame state with each word that leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else if (advance) begin
			frame_q <= frame_nxt;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lead_value <= LEAD_VALUE_RST;
			cfg_q.gap_reload <= GAP_RELOAD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_LEAD_VALUE: cfg_q.lead_value <= cfg.data;
				REG_GAP_RELOAD: cfg_q.gap_reload <= cfg.data;
				default: ;
			endcase
		end
	end

	llfr_step #(
		.MAX_FRAME_LEN (MAX_FRAME_LEN)
	) u_step (
		.item (item_s1),
		.cur  (frame_q),
		.cfg  (cfg_q),
		.nxt  (frame_nxt),
		.res  (step_res)
	);

	llfr_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (valid_s1),
		.res    (step_res),
		.free   (out_free),
		.result (result)
	);

endmodule : lead_length_frame_receiver_top
`default_nettype wire

>>> sv/llfr_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llfr_step : one step of the deframer
// Works out the result word and the next frame state for one item.
// ----------------------------------------------------------------------------
module llfr_step #(
	parameter logic [llfr_pkg::BYTE_W-1:0] MAX_FRAME_LEN = llfr_pkg::MAX_FRAME
) (
	input  wire llfr_pkg::llfr_item_t   item,
	input  wire llfr_pkg::llfr_frame_t  cur,
	input  wire llfr_pkg::llfr_cfg_t    cfg,
	output llfr_pkg::llfr_frame_t  nxt,
	output llfr_pkg::llfr_result_t res
);
	import llfr_pkg::*;

	logic              expired;
	logic [BYTE_W-1:0] pos0;
	logic [BYTE_W-1:0] len0;
	logic [BYTE_W-1:0] len1;
	logic [BYTE_W-1:0] pos1;
	logic              bad_len;
	logic              done;

	always_comb begin
		expired = (cur.gap_timer == '0);
		pos0    = expired ? '0 : cur.position;
		len0    = (expired && !cur.frame_ready) ? '0 : cur.current_length;
		bad_len = (item.rx_byte == '0) || (item.rx_byte > MAX_FRAME_LEN);
		if (pos0 == '0) begin
			len1 = '0;
		end else if (pos0 == BYTE_W'(1)) begin
			len1 = item.rx_byte;
		end else begin
			len1 = len0;
		end
		pos1 = pos0 + BYTE_W'(1);
		done = (pos1 >= BYTE_W'(2)) && (pos1 >= len1);
	end

	always_comb begin
		nxt = cur;
		res = '0;
		unique case (item.opcode)
			OP_TICK: begin
				if (cur.gap_timer != '0) begin
					nxt.gap_timer = cur.gap_timer - BYTE_W'(1);
				end
				res.status = ST_TICK;
			end
			OP_RELEASE: begin
				nxt.frame_ready    = 1'b0;
				nxt.current_length = '0;
				res.status         = ST_RELEASED;
			end
			OP_NONE: begin
				res.status = ST_IGNORED;
			end
			OP_BYTE: begin
				nxt.gap_timer      = cfg.gap_reload;
				nxt.position       = pos0;
				nxt.current_length = len0;
				res.gap_restart    = expired;
				res.frame_length   = len0;
				if (cur.frame_ready) begin
					res.status = ST_BUSY;
				end else if (pos0 == '0 && item.rx_byte != cfg.lead_value) begin
					res.status = ST_IGNORED;
				end else if (pos0 == BYTE_W'(1) && bad_len) begin
					// restart the hunt for a lead byte
					nxt.position       = '0;
					nxt.current_length = '0;
					res.status         = ST_LEN_ERR;
					res.frame_length   = '0;
				end else begin
					nxt.current_length = len1;
					res.byte_value     = item.rx_byte;
					res.byte_index     = pos0;
					res.frame_length   = len1;
					if (done) begin
						nxt.position    = '0;
						nxt.frame_ready = 1'b1;
						res.status      = ST_COMPLETE;
					end else begin
						nxt.position = pos1;
						res.status   = ST_STORED;
					end
				end
			end
			default: begin
				res.status = ST_IGNORED;
			end
		endcase
	end

endmodule : llfr_step
`default_nettype wire

>>> sv/llfr_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llfr_out_reg : result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module llfr_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire llfr_pkg::llfr_result_t res,
	output logic                  free,
	llfr_out_if.source            result
);
	import llfr_pkg::*;

	logic         valid_s2;
	llfr_result_t res_s2;

	assign free = !valid_s2 || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_s2 <= res;
		end
	end

	assign result.valid        = valid_s2;
	assign result.status       = res_s2.status;
	assign result.byte_value   = res_s2.byte_value;
	assign result.byte_index   = res_s2.byte_index;
	assign result.frame_length = res_s2.frame_length;
	assign result.gap_restart  = res_s2.gap_restart;

endmodule : llfr_out_reg
`default_nettype wire
